// ===== hdl/autocorrelation_peak_lag_finder_assert.svh =====
// Assertion macros used by the checker file.
`ifndef AUTOCORRELATION_PEAK_LAG_FINDER_ASSERT_SVH
`define AUTOCORRELATION_PEAK_LAG_FINDER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while reset is low.
`define ACPL_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("acpl: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while reset is low.
`define ACPL_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("acpl: next-cycle check failed");

`endif

// ===== hdl/acpl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package acpl_pkg;

  localparam int NCELL     = 8;
  localparam int SH_W      = $clog2(NCELL);
  localparam int LAG_W     = 9;
  localparam int MAG_W     = 16;
  localparam int RATE_W    = 10;
  localparam int LCFG_W    = 8;
  localparam int FREQ_W    = 18;
  localparam int REGQ_W    = 17;
  localparam int CFG_DW    = 10;
  localparam int CFG_IW    = 3;
  localparam int STEP_W    = 5;
  localparam int DRAIN_W   = 2;

  typedef enum logic [CFG_IW-1:0] {
    REG_SAMPLE_RATE    = 3'd0,
    REG_DOM_LAG_FIRST  = 3'd1,
    REG_DOM_LAG_LAST   = 3'd2,
    REG_STEP_LAG_FIRST = 3'd3,
    REG_STEP_LAG_LAST  = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_PCLR,
    S_RUN,
    S_DRAIN,
    S_SHIFT,
    S_DIV_FREQ,
    S_DIV_REG,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clr;
    logic run;
    logic shift;
    logic cur_valid;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/acpl_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module acpl_cell #(
  parameter int YW  = 26,
  parameter int ACW = 60
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  acpl_pkg::cell_ctl_t     ctl,
  input  wire logic signed [YW-1:0]  cur,
  input  wire logic signed [YW-1:0]  lag_in,
  input  wire                     lag_vld_in,
  input  wire logic signed [ACW-1:0] acc_in,
  output logic signed [YW-1:0]    lag_out,
  output logic                    lag_vld_out,
  output logic signed [ACW-1:0]   acc_out
);

  localparam int PW = 2 * YW;

  logic signed [YW-1:0]  lag_r;
  logic                  lag_vld_r;
  logic signed [PW-1:0]  prod_r;
  logic                  prod_vld_r;
  logic signed [ACW-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lag_vld_r  <= 1'b0;
      prod_vld_r <= 1'b0;
    end else if (ctl.clr) begin
      lag_vld_r  <= 1'b0;
      prod_vld_r <= 1'b0;
    end else if (ctl.run) begin
      lag_vld_r  <= lag_vld_in;
      prod_vld_r <= lag_vld_in & ctl.cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.run) begin
      lag_r  <= lag_in;
      prod_r <= PW'(cur) * PW'(lag_in);
    end
  end

  // The accumulator doubles as a stage of the readout shift line.
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (ctl.shift) begin
      acc_r <= acc_in;
    end else if (ctl.run && prod_vld_r) begin
      acc_r <= acc_r + ACW'(prod_r);
    end
  end

  assign lag_out     = lag_r;
  assign lag_vld_out = lag_vld_r;
  assign acc_out     = acc_r;

endmodule
`default_nettype wire

// ===== hdl/autocorrelation_peak_lag_finder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | in_magnitude, in_window_end
// out     | output    | out_valid / out_ready | dominant freq/lag, regularity, step lag,
//         |           |                      | zero energy
// cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// A sample that does not end the window is only stored and summed.
// A closing sample starts P passes, P = ceil((min(255, n-1) + 1) / 8), of the eight-cell lag chain,
// each clearing the chain and streaming the window through it once for a group of eight lags,
// then draining it and shifting the eight sums out; then, when the window has energy, serial division,
// and the result is loaded once the output register is free.
// Reset is synchronous; the sample store needs no clearing.
// in_ready is low while a window is processed; a result held by a stalled out_ready
// does not block loading of the next window.
module autocorrelation_peak_lag_finder #(
  parameter int MAX_WINDOW = 256
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire [acpl_pkg::MAG_W-1:0]        in_magnitude,
  input  wire                              in_window_end,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [acpl_pkg::FREQ_W-1:0]      out_dominant_freq_q8,
  output logic [acpl_pkg::LCFG_W-1:0]      out_dominant_lag,
  output logic [acpl_pkg::REGQ_W-1:0]      out_regularity_q16,
  output logic [acpl_pkg::LCFG_W-1:0]      out_step_lag,
  output logic                             out_zero_energy,
  input  wire                              cfg_we,
  input  wire [acpl_pkg::CFG_IW-1:0]       cfg_index,
  input  wire [acpl_pkg::CFG_DW-1:0]       cfg_data
);

  localparam int CW   = $clog2(MAX_WINDOW + 1);
  localparam int AW   = $clog2(MAX_WINDOW);
  localparam int NXW  = acpl_pkg::MAG_W + CW;
  localparam int YW   = NXW + 1;
  localparam int ACW  = 2 * YW + CW;
  localparam int KW   = acpl_pkg::LAG_W;
  localparam int XW   = (CW > KW) ? CW + 1 : KW + 1;
  localparam int NC   = acpl_pkg::NCELL;
  localparam int FW   = acpl_pkg::FREQ_W;
  localparam int QW   = acpl_pkg::REGQ_W;
  localparam int LW   = acpl_pkg::LCFG_W;

  // Configuration registers
  logic [acpl_pkg::RATE_W-1:0] rate_r;
  logic [LW-1:0] dfirst_r, dlast_r, sfirst_r, slast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r   <= acpl_pkg::RATE_W'(100);
      dfirst_r <= LW'(10);
      dlast_r  <= LW'(200);
      sfirst_r <= LW'(40);
      slast_r  <= LW'(199);
    end else if (cfg_we) begin
      case (cfg_index)
        acpl_pkg::REG_SAMPLE_RATE:    rate_r   <= cfg_data;
        acpl_pkg::REG_DOM_LAG_FIRST:  dfirst_r <= cfg_data[LW-1:0];
        acpl_pkg::REG_DOM_LAG_LAST:   dlast_r  <= cfg_data[LW-1:0];
        acpl_pkg::REG_STEP_LAG_FIRST: sfirst_r <= cfg_data[LW-1:0];
        acpl_pkg::REG_STEP_LAG_LAST:  slast_r  <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  acpl_pkg::state_t state_r, state_nxt;
  acpl_pkg::cell_ctl_t ctl;

  logic [CW-1:0]  cnt_r;
  logic [NXW-1:0] sum_r;
  logic [CW-1:0]  t_r;
  logic [KW-1:0]  base_r;
  logic [acpl_pkg::DRAIN_W-1:0] dr_r;
  logic [acpl_pkg::SH_W-1:0]    sh_r;
  logic [acpl_pkg::STEP_W-1:0]  step_r;

  logic in_acc, issue, out_free;
  assign in_acc   = in_valid & in_ready;
  assign out_free = ~out_valid | out_ready;

  // Lag ranges, with first lags raised to one and last lags clipped to n-1.
  logic [CW-1:0] n_m1;
  logic [XW-1:0] lmax, dlo, dhi, slo, shi, kx;
  logic [KW-1:0] k_emit;
  assign n_m1   = cnt_r - CW'(1);
  assign lmax   = (XW'(n_m1) > XW'(255)) ? XW'(255) : XW'(n_m1);
  assign dlo    = (dfirst_r == '0) ? XW'(1) : XW'(dfirst_r);
  assign slo    = (sfirst_r == '0) ? XW'(1) : XW'(sfirst_r);
  assign dhi    = (XW'(dlast_r) > XW'(n_m1)) ? XW'(n_m1) : XW'(dlast_r);
  assign shi    = (XW'(slast_r) > XW'(n_m1)) ? XW'(n_m1) : XW'(slast_r);
  assign k_emit = base_r + KW'(sh_r);
  assign kx     = XW'(k_emit);

  logic last_pass;
  assign last_pass = (XW'(base_r) + XW'(NC)) > lmax;

  // Trackers
  logic signed [ACW-1:0] r0_r, dbest_r, sbest_r;
  logic [LW-1:0] dlag_r, slag_r;
  logic dfound_r, sfound_r;
  logic dom_ok, step_ok, r0_zero;
  assign r0_zero = (r0_r == '0);
  assign dom_ok  = dfound_r && (dbest_r > 0);
  assign step_ok = sfound_r && (sbest_r > 0);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      acpl_pkg::S_LOAD:  if (in_acc && in_window_end) state_nxt = acpl_pkg::S_PCLR;
      acpl_pkg::S_PCLR:  state_nxt = acpl_pkg::S_RUN;
      acpl_pkg::S_RUN:   if (t_r == n_m1) state_nxt = acpl_pkg::S_DRAIN;
      acpl_pkg::S_DRAIN: if (dr_r == '1) state_nxt = acpl_pkg::S_SHIFT;
      acpl_pkg::S_SHIFT: begin
        if (sh_r == acpl_pkg::SH_W'(NC - 1)) begin
          if (!last_pass) state_nxt = acpl_pkg::S_PCLR;
          else if (r0_zero) state_nxt = acpl_pkg::S_DONE;
          else state_nxt = acpl_pkg::S_DIV_FREQ;
        end
      end
      acpl_pkg::S_DIV_FREQ: if (step_r == acpl_pkg::STEP_W'(FW - 1)) state_nxt = acpl_pkg::S_DIV_REG;
      acpl_pkg::S_DIV_REG:  if (step_r == acpl_pkg::STEP_W'(15)) state_nxt = acpl_pkg::S_DONE;
      acpl_pkg::S_DONE:     if (out_free) state_nxt = acpl_pkg::S_LOAD;
      default:              state_nxt = acpl_pkg::S_LOAD;
    endcase
  end

  logic va1_r, vb1_r, va2_r, vb2_r;

  // Outputs of the sequencer
  always_comb begin
    in_ready      = 1'b0;
    issue         = 1'b0;
    ctl.clr       = 1'b0;
    ctl.run       = 1'b0;
    ctl.shift     = 1'b0;
    ctl.cur_valid = va2_r;
    case (state_r)
      acpl_pkg::S_LOAD:  in_ready = 1'b1;
      acpl_pkg::S_PCLR:  ctl.clr = 1'b1;
      acpl_pkg::S_RUN: begin
        issue   = 1'b1;
        ctl.run = 1'b1;
      end
      acpl_pkg::S_DRAIN: ctl.run = 1'b1;
      acpl_pkg::S_SHIFT: ctl.shift = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= acpl_pkg::S_LOAD;
    else state_r <= state_nxt;
  end

  // Sample store, one write port and two registered read ports
  logic [acpl_pkg::MAG_W-1:0] mem [MAX_WINDOW];
  logic [acpl_pkg::MAG_W-1:0] xa_r, xb_r;
  logic [AW-1:0] ra, rb;
  logic b_ok;
  assign ra   = t_r[AW-1:0];
  assign b_ok = XW'(t_r) >= XW'(base_r);
  assign rb   = AW'(XW'(t_r) - XW'(base_r));

  always_ff @(posedge clk) begin
    if (in_acc && (XW'(cnt_r) < XW'(MAX_WINDOW))) mem[cnt_r[AW-1:0]] <= in_magnitude;
    xa_r <= mem[ra];
    xb_r <= mem[rb];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
    end else if (in_acc && (XW'(cnt_r) < XW'(MAX_WINDOW))) begin
      cnt_r <= cnt_r + CW'(1);
      sum_r <= sum_r + NXW'(in_magnitude);
    end else if (state_r == acpl_pkg::S_DONE && out_free) begin
      cnt_r <= '0;
      sum_r <= '0;
    end
  end

  // Mean removal: y = n*x - S
  logic [NXW-1:0] nx_a, nx_b;
  logic signed [YW-1:0] ya_r, yb_r;
  assign nx_a = NXW'(cnt_r) * NXW'(xa_r);
  assign nx_b = NXW'(cnt_r) * NXW'(xb_r);

  always_ff @(posedge clk) begin
    ya_r <= $signed({1'b0, nx_a}) - $signed({1'b0, sum_r});
    yb_r <= $signed({1'b0, nx_b}) - $signed({1'b0, sum_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va1_r <= 1'b0;
      vb1_r <= 1'b0;
      va2_r <= 1'b0;
      vb2_r <= 1'b0;
    end else begin
      va1_r <= issue;
      vb1_r <= issue & b_ok;
      va2_r <= va1_r;
      vb2_r <= vb1_r;
    end
  end

  // Pass counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r    <= '0;
      dr_r   <= '0;
      sh_r   <= '0;
      base_r <= '0;
    end else begin
      case (state_r)
        acpl_pkg::S_LOAD:  base_r <= '0;
        acpl_pkg::S_PCLR:  t_r <= '0;
        acpl_pkg::S_RUN: begin
          t_r  <= t_r + CW'(1);
          dr_r <= '0;
        end
        acpl_pkg::S_DRAIN: begin
          dr_r <= dr_r + acpl_pkg::DRAIN_W'(1);
          sh_r <= '0;
        end
        acpl_pkg::S_SHIFT: begin
          sh_r <= sh_r + acpl_pkg::SH_W'(1);
          if (sh_r == acpl_pkg::SH_W'(NC - 1)) base_r <= base_r + KW'(NC);
        end
        default: ;
      endcase
    end
  end

  // Chain of lag cells; cell c works on lag base + c.
  logic signed [YW-1:0]  lag_bus [NC+1];
  logic                  vld_bus [NC+1];
  logic signed [ACW-1:0] acc_bus [NC+1];

  assign lag_bus[0]  = yb_r;
  assign vld_bus[0]  = vb2_r;
  assign acc_bus[NC] = '0;

  for (genvar c = 0; c < NC; c++) begin : g_cell
    acpl_cell #(.YW(YW), .ACW(ACW)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .cur        (ya_r),
      .lag_in     (lag_bus[c]),
      .lag_vld_in (vld_bus[c]),
      .acc_in     (acc_bus[c+1]),
      .lag_out    (lag_bus[c+1]),
      .lag_vld_out(vld_bus[c+1]),
      .acc_out    (acc_bus[c])
    );
  end

  // Peak tracking on the lag values shifted out of the chain
  logic signed [ACW-1:0] r_emit;
  assign r_emit = acc_bus[0];

  always_ff @(posedge clk) begin
    if (state_r == acpl_pkg::S_LOAD) begin
      dlag_r   <= dlo[LW-1:0];
      slag_r   <= slo[LW-1:0];
      dfound_r <= 1'b0;
      sfound_r <= 1'b0;
      dbest_r  <= '0;
      sbest_r  <= '0;
      r0_r     <= '0;
    end else if (state_r == acpl_pkg::S_SHIFT) begin
      if (k_emit == '0) r0_r <= r_emit;
      if (kx >= dlo && kx <= dhi && (!dfound_r || r_emit > dbest_r)) begin
        dbest_r  <= r_emit;
        dlag_r   <= k_emit[LW-1:0];
        dfound_r <= 1'b1;
      end
      if (kx >= slo && kx <= shi && (!sfound_r || r_emit > sbest_r)) begin
        sbest_r  <= r_emit;
        slag_r   <= k_emit[LW-1:0];
        sfound_r <= 1'b1;
      end
    end
  end

  // Serial restoring divider, one quotient bit a cycle, shared by both ratios
  logic [ACW-1:0] rem_r, rem_sh, den;
  logic [FW-1:0]  num_r, q_r, q_step, freq_r;
  logic           ge;
  assign den    = (state_r == acpl_pkg::S_DIV_FREQ) ? ACW'(dlag_r) : ACW'(r0_r);
  assign rem_sh = (state_r == acpl_pkg::S_DIV_FREQ) ? {rem_r[ACW-2:0], num_r[FW-1]}
                                                    : {rem_r[ACW-2:0], 1'b0};
  assign ge     = rem_sh >= den;
  assign q_step = {q_r[FW-2:0], ge};

  // The dominant peak is only final after the last lag has been shifted out,
  // so the frequency is gated when the quotient is taken.
  always_ff @(posedge clk) begin
    if (state_r == acpl_pkg::S_SHIFT) begin
      rem_r  <= '0;
      q_r    <= '0;
      step_r <= '0;
      num_r  <= {rate_r, 8'b0};
    end else if (state_r == acpl_pkg::S_DIV_FREQ || state_r == acpl_pkg::S_DIV_REG) begin
      num_r <= {num_r[FW-2:0], 1'b0};
      if (state_r == acpl_pkg::S_DIV_FREQ && step_r == acpl_pkg::STEP_W'(FW - 1)) begin
        freq_r <= dom_ok ? q_step : '0;
        rem_r  <= ACW'(sbest_r);
        q_r    <= '0;
        step_r <= '0;
      end else begin
        rem_r  <= ge ? rem_sh - den : rem_sh;
        q_r    <= q_step;
        step_r <= step_r + acpl_pkg::STEP_W'(1);
      end
    end
  end

  // Result register
  logic [QW-1:0] reg_val;
  assign reg_val = !step_ok ? '0 :
                   (sbest_r >= r0_r) ? QW'(65536) : QW'(q_r[15:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (state_r == acpl_pkg::S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == acpl_pkg::S_DONE && out_free) begin
      out_zero_energy      <= r0_zero;
      out_dominant_freq_q8 <= r0_zero ? '0 : freq_r;
      out_dominant_lag     <= r0_zero ? '0 : dlag_r;
      out_regularity_q16   <= r0_zero ? '0 : reg_val;
      out_step_lag         <= r0_zero ? slo[LW-1:0] : slag_r;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/acpl_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "autocorrelation_peak_lag_finder_assert.svh"
module acpl_checker (
  input wire                         clk,
  input wire                         rst_n,
  input wire                         in_valid,
  input wire                         in_ready,
  input wire                         in_window_end,
  input wire                         out_valid,
  input wire                         out_ready,
  input wire [acpl_pkg::FREQ_W-1:0]  out_dominant_freq_q8,
  input wire [acpl_pkg::LCFG_W-1:0]  out_dominant_lag,
  input wire [acpl_pkg::REGQ_W-1:0]  out_regularity_q16,
  input wire                         out_zero_energy
);

  // A held result keeps its payload.
  `ACPL_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_dominant_freq_q8) && $stable(out_regularity_q16))

  // The item that closes a window stops intake while the window is processed.
  `ACPL_ASSERT_NXT(a_busy_after_end, in_valid && in_ready && in_window_end, !in_ready)

  // A window without energy reports no peak.
  `ACPL_ASSERT_IMP(a_zero_energy, out_valid && out_zero_energy,
    out_dominant_freq_q8 == 0 && out_dominant_lag == 0 && out_regularity_q16 == 0)

  // A nonzero frequency always comes with a nonzero lag and a bounded ratio.
  `ACPL_ASSERT_IMP(a_freq_lag, out_valid && out_dominant_freq_q8 != 0,
    out_dominant_lag != 0 && out_regularity_q16 <= 17'd65536)

endmodule

bind autocorrelation_peak_lag_finder acpl_checker u_acpl_checker (.*);
`default_nettype wire

// ===== bench/tb_autocorrelation_peak_lag_finder.sv =====
`timescale 1ns / 1ps

typedef struct {
  bit [17:0] freq_q8;
  bit [7:0]  dom_lag;
  bit [16:0] regul_q16;
  bit [7:0]  stp_lag;
  bit        zero_en;
} peak_result_t;

class acorr_scoreboard;
  bit [15:0] window_mem[256];
  longint    win_sum;
  int        win_count;
  int        rate_hz, dom_first, dom_last, stp_first, stp_last;
  peak_result_t pending_peaks[$];
  int errors;
  int windows_done;

  function new();
    rate_hz = 100; dom_first = 10; dom_last = 200; stp_first = 40; stp_last = 199;
    win_sum = 0; win_count = 0; errors = 0; windows_done = 0;
  endfunction

  function void set_reg(acpl_pkg::reg_idx_t idx, int val);
    case (idx)
      acpl_pkg::REG_SAMPLE_RATE:    rate_hz = val & 'h3ff;
      acpl_pkg::REG_DOM_LAG_FIRST:  dom_first = val & 'hff;
      acpl_pkg::REG_DOM_LAG_LAST:   dom_last = val & 'hff;
      acpl_pkg::REG_STEP_LAG_FIRST: stp_first = val & 'hff;
      acpl_pkg::REG_STEP_LAG_LAST:  stp_last = val & 'hff;
      default: ;
    endcase
  endfunction

  // Deviations are scaled by n so the mean comes out exactly.
  function longint dev(int i, int n);
    return longint'(n) * longint'(window_mem[i]) - win_sum;
  endfunction

  function longint lag_product(int k, int n);
    longint acc;
    acc = 0;
    for (int i = 0; i + k < n; i++) acc += dev(i, n) * dev(i + k, n);
    return acc;
  endfunction

  function int find_peak(int first, int last, int n, output longint best, output bit any);
    int hi, lag;
    longint r;
    hi = (last > n - 1) ? n - 1 : last;
    lag = first; best = 0; any = 0;
    for (int k = first; k <= hi; k++) begin
      r = lag_product(k, n);
      if (!any || r > best) begin
        best = r; lag = k; any = 1;
      end
    end
    return lag;
  endfunction

  function int ratio_q16(longint num, longint den);
    longint rem;
    int q;
    if (num >= den) return 65536;
    rem = num; q = 0;
    for (int b = 0; b < 16; b++) begin
      rem = rem << 1; q = q << 1;
      if (rem >= den) begin
        rem -= den; q |= 1;
      end
    end
    return q;
  endfunction

  function void note_sample(bit [15:0] mag, bit last);
    int n, dlo, slo, dl, sl;
    longint r0, db, sb;
    bit df, sf;
    peak_result_t res;
    if (win_count < 256) begin
      window_mem[win_count] = mag; win_sum += mag; win_count++;
    end
    if (!last) return;
    n = win_count;
    dlo = (dom_first < 1) ? 1 : dom_first;
    slo = (stp_first < 1) ? 1 : stp_first;
    r0 = 0;
    for (int i = 0; i < n; i++) r0 += dev(i, n) * dev(i, n);
    res = '{default: 0};
    if (r0 == 0) begin
      res.stp_lag = 8'(slo); res.zero_en = 1;
    end else begin
      dl = find_peak(dlo, dom_last, n, db, df);
      sl = find_peak(slo, stp_last, n, sb, sf);
      if (df && db > 0) res.freq_q8 = 18'((rate_hz * 256) / dl);
      if (sf && sb > 0) res.regul_q16 = 17'(ratio_q16(sb, r0));
      res.dom_lag = 8'(dl); res.stp_lag = 8'(sl);
    end
    pending_peaks.push_back(res);
    win_sum = 0; win_count = 0;
  endfunction

  function void check_result(peak_result_t got);
    peak_result_t want;
    if (pending_peaks.size() == 0) begin
      $display("%0t: unexpected result freq=%0d", $time, got.freq_q8);
      errors++;
      return;
    end
    want = pending_peaks.pop_front();
    windows_done++;
    if (want.freq_q8 != got.freq_q8) begin
      $display("%0t: freq_q8 exp %0d got %0d", $time, want.freq_q8, got.freq_q8); errors++;
    end
    if (want.dom_lag != got.dom_lag) begin
      $display("%0t: dom_lag exp %0d got %0d", $time, want.dom_lag, got.dom_lag); errors++;
    end
    if (want.regul_q16 != got.regul_q16) begin
      $display("%0t: regularity exp %0d got %0d", $time, want.regul_q16, got.regul_q16);
      errors++;
    end
    if (want.stp_lag != got.stp_lag) begin
      $display("%0t: step_lag exp %0d got %0d", $time, want.stp_lag, got.stp_lag); errors++;
    end
    if (want.zero_en != got.zero_en) begin
      $display("%0t: zero_energy exp %0d got %0d", $time, want.zero_en, got.zero_en);
      errors++;
    end
  endfunction
endclass

module tb_autocorrelation_peak_lag_finder;
  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_ready;
  logic [15:0] in_magnitude = 0;
  logic in_window_end = 0;
  logic out_valid, out_ready = 0;
  logic [17:0] out_dominant_freq_q8;
  logic [7:0]  out_dominant_lag, out_step_lag;
  logic [16:0] out_regularity_q16;
  logic out_zero_energy;
  logic cfg_we = 0;
  logic [acpl_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [acpl_pkg::CFG_DW-1:0] cfg_data = '0;

  acorr_scoreboard sb = new();
  bit idle_on = 1;
  int hold_left = 0;
  int items_sent = 0;

  autocorrelation_peak_lag_finder i_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready = 0;
    end else begin
      out_ready = !(idle_on && $urandom_range(99) < 25);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_dominant_freq_q8, out_dominant_lag, out_regularity_q16,
                        out_step_lag, out_zero_energy});
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_sample(bit [15:0] mag, bit last);
    while (idle_on && $urandom_range(99) < 25) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1; in_magnitude = mag; in_window_end = last;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(mag, last);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic bit [15:0] pick_sample(int mode, int i, int period, int base);
    case (mode)
      0: return 16'($urandom);
      1: return 16'(base);
      2: return 16'(base + (((i % period) < period / 2) ? 3000 : 0) + $urandom_range(200));
      default: return 16'(base + $urandom_range(50));
    endcase
  endfunction

  task automatic send_window(int len);
    int mode, period, base;
    mode = $urandom_range(9) < 5 ? 2 : $urandom_range(3);
    period = $urandom_range(2, 24);
    base = $urandom_range(60000);
    for (int i = 0; i < len; i++) send_sample(pick_sample(mode, i, period, base), i == len - 1);
    in_valid = 0;
  endtask

  task automatic wait_idle();
    while (sb.pending_peaks.size() > 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(acpl_pkg::reg_idx_t idx, int val);
    cfg_we = 1; cfg_index = idx; cfg_data = acpl_pkg::CFG_DW'(val);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic set_all(int rate, int df, int dl, int sf, int sl);
    write_reg(acpl_pkg::REG_SAMPLE_RATE, rate);
    write_reg(acpl_pkg::REG_DOM_LAG_FIRST, df);
    write_reg(acpl_pkg::REG_DOM_LAG_LAST, dl);
    write_reg(acpl_pkg::REG_STEP_LAG_FIRST, sf);
    write_reg(acpl_pkg::REG_STEP_LAG_LAST, sl);
  endtask

  initial begin
    int len, phase_start;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: one-sample window, flat window, full-scale swing, short ramp
    // whose step lag range is empty under the reset settings.
    send_sample(16'h1234, 1);
    for (int i = 0; i < 3; i++) send_sample(16'd500, i == 2);
    for (int i = 0; i < 8; i++) send_sample((i % 2) ? 16'hffff : 16'h0000, i == 7);
    for (int i = 0; i < 12; i++) send_sample(16'(i * 5000), i == 11);
    in_valid = 0;
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_all(100, 1, 255, 1, 255);
        1: set_all(1023, 0, 3, 0, 5);
        2: set_all(0, 255, 255, 255, 255);
        3: set_all(1, 2, 1, 5, 2);
        4: set_all(1000, 10, 200, 40, 199);
        default: set_all($urandom_range(1023), $urandom_range(255), $urandom_range(255),
                         $urandom_range(255), $urandom_range(255));
      endcase
      idle_on = (ph != 2);
      if (ph == 1) hold_left = 3000;
      phase_start = items_sent;
      while (items_sent - phase_start < 100) begin
        case ($urandom_range(99) / 3)
          0: len = $urandom_range(257, 300);
          1, 2: len = $urandom_range(41, 200);
          default: len = $urandom_range(1, 40);
        endcase
        send_window(len);
      end
      wait_idle();
    end

    $display("Sent %0d samples in %0d windows over six register settings,",
             items_sent, sb.windows_done);
    $display("with flat, full-scale, periodic and overlong windows.");
    if (sb.errors == 0 && sb.pending_peaks.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end
endmodule
